FILE: hw/rtl/pidaw_pkg.sv
// Shared types, constants and helpers for the PID controller with anti-windup.
// Used by pidaw_mac, pidaw_ctrl and pid_antiwindup_controller; depends on nothing.

package pidaw_pkg;

  // Fixed formats: 24-bit unsigned gains, 32-bit internal terms.
  localparam int GAIN_W     = 24;
  localparam int TERM_W     = 32;
  localparam int SERR_W     = TERM_W + 1;
  localparam int MUL_A_W    = TERM_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int CFG_ADDR_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_WINDUP_GAIN = 3'd3,
    REG_OUT_UPPER   = 3'd4,
    REG_OUT_LOWER   = 3'd5
  } reg_idx_t;

  // Operand and gain pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    MUL_ERR,
    MUL_UP,
    MUL_SERR,
    MUL_DIFF
  } mul_sel_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_RND_P,
    ST_MUL_I,
    ST_RND_I,
    ST_RND_C,
    ST_RND_D,
    ST_SUM,
    ST_OUT,
    ST_CLR
  } state_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic     s_ready;
    logic     ld_in;
    mul_sel_t mul_sel;
    logic     ld_up;
    logic     ld_diff;
    logic     ld_iacc;
    logic     ld_integ;
    logic     ld_usum;
    logic     ld_pre;
    logic     commit;
    logic     zero;
  } ctrl_t;

  // Saturate a wide signed sum to the signed 32-bit term range.
  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [ACC_W-1:0] x);
    logic signed [TERM_W-1:0] res;
    if (x[ACC_W-1:TERM_W-1] == '0 || x[ACC_W-1:TERM_W-1] == '1) begin
      res = x[TERM_W-1:0];
    end else if (x[ACC_W-1]) begin
      res = {1'b1, {(TERM_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(TERM_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/pidaw_mac.sv
// Shared gain multiplier: selects an operand and its gain, registers the exact
// product and rounds it half up by the gain fraction bits. Depends on pidaw_pkg.

module pidaw_mac #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  pidaw_pkg::mul_sel_t                 sel,
  input  logic signed [pidaw_pkg::MUL_A_W-1:0] err_op,
  input  logic signed [pidaw_pkg::MUL_A_W-1:0] up_op,
  input  logic signed [pidaw_pkg::MUL_A_W-1:0] serr_op,
  input  logic signed [pidaw_pkg::MUL_A_W-1:0] diff_op,
  input  logic [pidaw_pkg::GAIN_W-1:0]        prop_gain,
  input  logic [pidaw_pkg::GAIN_W-1:0]        integ_gain,
  input  logic [pidaw_pkg::GAIN_W-1:0]        deriv_gain,
  input  logic [pidaw_pkg::GAIN_W-1:0]        windup_gain,
  output logic signed [pidaw_pkg::ACC_W-1:0]  rnd
);

  localparam int PW = pidaw_pkg::PROD_W;
  localparam logic signed [PW:0] HALF = (PW+1)'(1) << (GAIN_FRAC_BITS - 1);

  logic signed [pidaw_pkg::MUL_A_W-1:0] opa;
  logic [pidaw_pkg::GAIN_W-1:0]         gain;
  logic signed [pidaw_pkg::MUL_B_W-1:0] gain_s;
  logic signed [PW-1:0]                 prod;
  logic signed [PW:0]                   biased;
  logic signed [PW:0]                   shifted;

  // Operand and gain selection.
  always_comb begin
    case (sel)
      pidaw_pkg::MUL_ERR: begin
        opa  = err_op;
        gain = prop_gain;
      end
      pidaw_pkg::MUL_UP: begin
        opa  = up_op;
        gain = integ_gain;
      end
      pidaw_pkg::MUL_SERR: begin
        opa  = serr_op;
        gain = windup_gain;
      end
      pidaw_pkg::MUL_DIFF: begin
        opa  = diff_op;
        gain = deriv_gain;
      end
      default: begin
        opa  = err_op;
        gain = prop_gain;
      end
    endcase
  end

  assign gain_s = $signed({1'b0, gain});

  // Exact product, registered before any further arithmetic.
  always_ff @(posedge clk) begin
    prod <= PW'(opa) * PW'(gain_s);
  end

  // Round half toward plus infinity, then drop the fraction bits.
  assign biased  = (PW+1)'(prod) + HALF;
  assign shifted = biased >>> GAIN_FRAC_BITS;
  assign rnd     = pidaw_pkg::ACC_W'(shifted);

endmodule

FILE: hw/rtl/pidaw_ctrl.sv
// Sequencer for one PID step: walks the shared multiplier through the four
// gain products and the final clamp. Depends on pidaw_pkg.

module pidaw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             in_clear,
  input  logic             out_free,
  output pidaw_pkg::ctrl_t ctrl
);

  pidaw_pkg::state_t state;
  pidaw_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidaw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_next   = state;
    ctrl         = '0;
    ctrl.mul_sel = pidaw_pkg::MUL_ERR;
    case (state)
      pidaw_pkg::ST_IDLE: begin
        ctrl.s_ready = 1'b1;
        if (s_tvalid) begin
          ctrl.ld_in = 1'b1;
          state_next = in_clear ? pidaw_pkg::ST_CLR : pidaw_pkg::ST_MUL_P;
        end
      end
      pidaw_pkg::ST_MUL_P: begin
        ctrl.mul_sel = pidaw_pkg::MUL_ERR;
        state_next   = pidaw_pkg::ST_RND_P;
      end
      pidaw_pkg::ST_RND_P: begin
        ctrl.ld_up = 1'b1;
        state_next = pidaw_pkg::ST_MUL_I;
      end
      pidaw_pkg::ST_MUL_I: begin
        ctrl.mul_sel = pidaw_pkg::MUL_UP;
        ctrl.ld_diff = 1'b1;
        state_next   = pidaw_pkg::ST_RND_I;
      end
      pidaw_pkg::ST_RND_I: begin
        ctrl.ld_iacc = 1'b1;
        ctrl.mul_sel = pidaw_pkg::MUL_SERR;
        state_next   = pidaw_pkg::ST_RND_C;
      end
      pidaw_pkg::ST_RND_C: begin
        ctrl.ld_integ = 1'b1;
        ctrl.mul_sel  = pidaw_pkg::MUL_DIFF;
        state_next    = pidaw_pkg::ST_RND_D;
      end
      pidaw_pkg::ST_RND_D: begin
        ctrl.ld_usum = 1'b1;
        state_next   = pidaw_pkg::ST_SUM;
      end
      pidaw_pkg::ST_SUM: begin
        ctrl.ld_pre = 1'b1;
        state_next  = pidaw_pkg::ST_OUT;
      end
      pidaw_pkg::ST_OUT: begin
        // Hold the finished step until the output register is free.
        if (out_free) begin
          ctrl.commit = 1'b1;
          state_next  = pidaw_pkg::ST_IDLE;
        end
      end
      pidaw_pkg::ST_CLR: begin
        if (out_free) begin
          ctrl.zero  = 1'b1;
          state_next = pidaw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pidaw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/pid_antiwindup_controller.sv
// Positional PID controller with clamping anti-windup, one shared multiplier.
// A sample walks the states MUL_P, RND_P, MUL_I, RND_I, RND_C, RND_D, SUM and OUT, a
// clear request CLR; the next request is taken only back in IDLE, as the four gain
// products take turns on the multiplier plus sum and clamp; a held result stalls.
// Reset (rst, synchronous): gains 0, limits at full scale, kept terms zeroed.
// Depends on pidaw_pkg, pidaw_mac and pidaw_ctrl.

module pid_antiwindup_controller #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // Request input.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: reference, feedback (lowest bits first), zero padded to bytes.
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
  // s_tuser: clear.
  input  logic [0:0]                          s_tuser,
  // Result output.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: drive, zero padded to bytes.
  output logic [((DATA_WIDTH+7)/8)*8-1:0]     m_tdata,
  // m_tuser: clamped.
  output logic [0:0]                          m_tuser,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [pidaw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [((DATA_WIDTH > pidaw_pkg::GAIN_W) ? DATA_WIDTH
                 : pidaw_pkg::GAIN_W)-1:0]    cfg_wdata
);

  localparam int TW  = pidaw_pkg::TERM_W;
  localparam int SW  = pidaw_pkg::SERR_W;
  localparam int AW  = pidaw_pkg::ACC_W;
  localparam int MW  = pidaw_pkg::MUL_A_W;
  localparam int GW  = pidaw_pkg::GAIN_W;
  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  pidaw_pkg::ctrl_t ctrl;

  // Configuration registers.
  logic [GW-1:0]                prop_gain;
  logic [GW-1:0]                integ_gain;
  logic [GW-1:0]                deriv_gain;
  logic [GW-1:0]                windup_gain;
  logic signed [DATA_WIDTH-1:0] out_upper;
  logic signed [DATA_WIDTH-1:0] out_lower;

  // Kept terms.
  logic signed [TW-1:0] integ_q;
  logic signed [TW-1:0] prev_q;
  logic signed [SW-1:0] sat_err_q;

  // Working registers of one step.
  logic signed [DATA_WIDTH:0] err_q;
  logic signed [TW-1:0]       up_q;
  logic signed [SW-1:0]       diff_q;
  logic signed [AW-1:0]       iacc_q;
  logic signed [SW-1:0]       usum_q;
  logic signed [TW-1:0]       pre_q;

  // Output register.
  logic                  out_valid;
  logic [DATA_WIDTH-1:0] drive_q;
  logic                  clamped_q;

  logic signed [DATA_WIDTH-1:0] in_ref;
  logic signed [DATA_WIDTH-1:0] in_fb;
  logic signed [AW-1:0]         rnd;
  logic signed [TW-1:0]         rnd_sat;
  logic signed [TW-1:0]         upper_ext;
  logic signed [TW-1:0]         lower_ext;
  logic signed [DATA_WIDTH-1:0] drv;
  logic                         clip;
  logic signed [SW-1:0]         sat_err_next;

  assign in_ref = s_tdata[DATA_WIDTH-1:0];
  assign in_fb  = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

  // Sequencer.
  pidaw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_clear (s_tuser[0]),
    .out_free (!out_valid || m_tready),
    .ctrl     (ctrl)
  );

  // Shared multiplier with rounding.
  pidaw_mac #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mac (
    .clk         (clk),
    .sel         (ctrl.mul_sel),
    .err_op      (MW'(err_q)),
    .up_op       (MW'(up_q)),
    .serr_op     (MW'(sat_err_q)),
    .diff_op     (MW'(diff_q)),
    .prop_gain   (prop_gain),
    .integ_gain  (integ_gain),
    .deriv_gain  (deriv_gain),
    .windup_gain (windup_gain),
    .rnd         (rnd)
  );

  assign rnd_sat = pidaw_pkg::sat_term(rnd);

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      windup_gain <= '0;
      out_upper   <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      out_lower   <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else if (cfg_we) begin
      case (cfg_addr)
        pidaw_pkg::REG_PROP_GAIN:   prop_gain   <= cfg_wdata[GW-1:0];
        pidaw_pkg::REG_INTEG_GAIN:  integ_gain  <= cfg_wdata[GW-1:0];
        pidaw_pkg::REG_DERIV_GAIN:  deriv_gain  <= cfg_wdata[GW-1:0];
        pidaw_pkg::REG_WINDUP_GAIN: windup_gain <= cfg_wdata[GW-1:0];
        pidaw_pkg::REG_OUT_UPPER:   out_upper   <= cfg_wdata[DATA_WIDTH-1:0];
        pidaw_pkg::REG_OUT_LOWER:   out_lower   <= cfg_wdata[DATA_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Step datapath: each register loads in its own sequencer state.
  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      err_q <= (DATA_WIDTH+1)'(in_ref) - (DATA_WIDTH+1)'(in_fb);
    end
    if (ctrl.ld_up) begin
      up_q <= rnd_sat;
    end
    if (ctrl.ld_diff) begin
      diff_q <= SW'(up_q) - SW'(prev_q);
    end
    if (ctrl.ld_iacc) begin
      iacc_q <= AW'(integ_q) + rnd;
    end
    if (ctrl.ld_usum) begin
      usum_q <= SW'(up_q) + SW'(rnd_sat);
    end
    if (ctrl.ld_pre) begin
      pre_q <= pidaw_pkg::sat_term(AW'(usum_q) + AW'(integ_q));
    end
  end

  // Output clamp, upper limit tested first.
  assign upper_ext = TW'(out_upper);
  assign lower_ext = TW'(out_lower);

  always_comb begin
    if (pre_q > upper_ext) begin
      drv  = out_upper;
      clip = 1'b1;
    end else if (pre_q < lower_ext) begin
      drv  = out_lower;
      clip = 1'b1;
    end else begin
      drv  = pre_q[DATA_WIDTH-1:0];
      clip = 1'b0;
    end
  end

  assign sat_err_next = SW'(drv) - SW'(pre_q);

  // Kept terms: integrator updates mid-step, the rest when the step finishes.
  always_ff @(posedge clk) begin
    if (rst || ctrl.zero) begin
      integ_q   <= '0;
      prev_q    <= '0;
      sat_err_q <= '0;
    end else begin
      if (ctrl.ld_integ) begin
        integ_q <= pidaw_pkg::sat_term(iacc_q + rnd);
      end
      if (ctrl.commit) begin
        prev_q    <= up_q;
        sat_err_q <= sat_err_next;
      end
    end
  end

  // Output register; a new result loads only once the old one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit || ctrl.zero) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.zero) begin
      drive_q   <= '0;
      clamped_q <= 1'b0;
    end else if (ctrl.commit) begin
      drive_q   <= drv;
      clamped_q <= clip;
    end
  end

  // No request is taken while reset is held.
  assign s_tready = ctrl.s_ready && !rst;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(drive_q);
  assign m_tuser  = clamped_q;

`ifndef NO_ASSERTIONS
  // A finished step never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.commit || ctrl.zero) |-> (!out_valid || m_tready))
    else $error("result register overwritten");

  // A clear request leaves every kept term at zero.
  assert property (@(posedge clk) disable iff (rst)
    ctrl.zero |=> (integ_q == '0 && prev_q == '0 && sat_err_q == '0))
    else $error("clear left a kept term nonzero");

  // An unclamped result carries no saturation error into the next step.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !clamped_q) |-> (sat_err_q == '0))
    else $error("saturation error without clamping");

  // Only one request is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while busy");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for pid_antiwindup_controller: a directed table, then random requests.
// Results are predicted by a fixed-point PID model kept in this file.
// Depends on pidaw_pkg and the controller RTL.

module tb;

  localparam int DW          = 16;
  localparam int FRAC        = 16;
  localparam int GW          = pidaw_pkg::GAIN_W;
  localparam int IDX_W       = pidaw_pkg::CFG_ADDR_W;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int BATCHES     = 16;
  localparam int BATCH_LEN   = 100;
  localparam int SHOWN_MAX   = 10;
  localparam int PLAN_LEN    = 38;

  localparam longint TERM_MAX = 64'sd2147483647;
  localparam longint TERM_MIN = -64'sd2147483648;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

  // One controller result as seen on the output stream.
  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 clamped;
  } pid_out_t;

  typedef enum bit {ROW_WRITE, ROW_SEND} row_kind_t;

  // Directed step: a register write or a request, with an optional typed-in result.
  typedef struct packed {
    row_kind_t            kind;
    logic [IDX_W-1:0]     addr;
    logic [GW-1:0]        wdata;
    logic                 clr;
    logic signed [DW-1:0] sp;
    logic signed [DW-1:0] fb;
    bit                   typed;
    logic signed [DW-1:0] exp_drive;
    logic                 exp_clamped;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // Zero gains after reset give zero drive.
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd0, 1'b0},
    // Unity Kp: drive is the error, clamped at full scale.
    '{ROW_WRITE, pidaw_pkg::REG_PROP_GAIN, 24'h010000,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 1'b1},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 1'b1},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd100, 16'sd40, 1'b1, 16'sd60, 1'b0},
    // Narrow limits; the lower one carries junk above its 16 bits.
    '{ROW_WRITE, pidaw_pkg::REG_OUT_UPPER, 24'h0003E8,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_OUT_LOWER, 24'hFFFC18,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd5000, 16'sd0, 1'b1, 16'sd1000, 1'b1},
    '{ROW_SEND,  '0, '0, 1'b0, -16'sd5000, 16'sd0, 1'b1, -16'sd1000, 1'b1},
    // Clear ignores the samples.
    '{ROW_SEND,  '0, '0, 1'b1, 16'sd1234, -16'sd4321, 1'b1, 16'sd0, 1'b0},
    // Integrator, derivative and windup feedback in play.
    '{ROW_WRITE, pidaw_pkg::REG_INTEG_GAIN, 24'h008000,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_DERIV_GAIN, 24'h004000,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_WINDUP_GAIN, 24'h010000,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd3000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd3000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd3000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, -16'sd3000, 16'sd500, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    // Crossed limits: the upper test wins.
    '{ROW_WRITE, pidaw_pkg::REG_OUT_UPPER, 24'hFFFF9C,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_OUT_LOWER, 24'h000064,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd2000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, -16'sd2000, 16'sd0, 1'b0, 16'sd0, 1'b0},
    // Writes to unmapped indexes are dropped.
    '{ROW_WRITE, REG_UNMAPPED_A, 24'hFFFFFF, 1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, REG_UNMAPPED_B, 24'h123456, 1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sd50, 16'sd0, 1'b0, 16'sd0, 1'b0},
    // Maximum gains push the integrator and the summed output into saturation.
    '{ROW_WRITE, pidaw_pkg::REG_PROP_GAIN, 24'hFFFFFF,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_INTEG_GAIN, 24'hFFFFFF,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_DERIV_GAIN, 24'hFFFFFF,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_WINDUP_GAIN, 24'hFFFFFF,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_OUT_UPPER, 24'h007FFF,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE, pidaw_pkg::REG_OUT_LOWER, 24'h008000,
      1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b1, -16'sd1, -16'sd1, 1'b1, 16'sd0, 1'b0},
    '{ROW_SEND,  '0, '0, 1'b0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sd0, 1'b0}
  };

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [31:0]      s_tdata   = '0;  // reference [15:0], feedback [31:16]
  logic [0:0]       s_tuser   = '0;  // clear [0]
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [15:0]      m_tdata;         // drive [15:0]
  logic [0:0]       m_tuser;         // clamped [0]
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_addr  = '0;
  logic [GW-1:0]    cfg_wdata = '0;

  // Predictor copy of the registers and the kept terms.
  logic [GW-1:0]        kp = '0, ki = '0, kd = '0, kc = '0;
  logic signed [DW-1:0] lim_hi = 16'sh7FFF;
  logic signed [DW-1:0] lim_lo = 16'sh8000;
  longint               integ_acc = 0, last_up = 0, sat_err = 0;

  pid_out_t drive_q [$];
  int       mismatches    = 0;
  bit       tx_idle       = 1'b1;
  bit       rx_idle       = 1'b1;
  bit       hold_results  = 1'b0;

  pid_antiwindup_controller #(
    .DATA_WIDTH     (DW),
    .GAIN_FRAC_BITS (FRAC)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Exact product with an unsigned gain, rounded half up, then floored.
  function automatic longint apply_gain(input longint x, input logic [GW-1:0] g);
    longint p;
    p = x * longint'({40'd0, g});
    p = p + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic longint sat_to_term(input longint x);
    if (x > TERM_MAX) return TERM_MAX;
    if (x < TERM_MIN) return TERM_MIN;
    return x;
  endfunction

  // One controller step; updates the kept terms and returns the result.
  function automatic pid_out_t predict_step(input logic clr, input logic signed [DW-1:0] sp,
                                            input logic signed [DW-1:0] fb);
    longint   err, up, ud, pre, drv;
    pid_out_t res;
    res = '0;
    if (clr) begin
      integ_acc = 0;
      last_up   = 0;
      sat_err   = 0;
      return res;
    end
    err = longint'(sp) - longint'(fb);
    up = sat_to_term(apply_gain(err, kp));
    integ_acc = sat_to_term(integ_acc + apply_gain(up, ki) + apply_gain(sat_err, kc));
    ud = sat_to_term(apply_gain(up - last_up, kd));
    pre = sat_to_term(up + integ_acc + ud);
    drv = pre;
    // The upper limit is tested first, so it wins when the limits cross.
    if (pre > longint'(lim_hi)) begin
      drv = lim_hi;
      res.clamped = 1'b1;
    end else if (pre < longint'(lim_lo)) begin
      drv = lim_lo;
      res.clamped = 1'b1;
    end
    sat_err = drv - pre;
    last_up = up;
    res.drive = drv[DW-1:0];
    return res;
  endfunction

  // Extreme sample values.
  function automatic logic signed [DW-1:0] rail_sample();
    case ($urandom_range(0, 3))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  // Register write; mirrored into the predictor.
  task automatic write_reg(input logic [IDX_W-1:0] addr, input logic [GW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      pidaw_pkg::REG_PROP_GAIN:   kp = data;
      pidaw_pkg::REG_INTEG_GAIN:  ki = data;
      pidaw_pkg::REG_DERIV_GAIN:  kd = data;
      pidaw_pkg::REG_WINDUP_GAIN: kc = data;
      pidaw_pkg::REG_OUT_UPPER:   lim_hi = data[DW-1:0];
      pidaw_pkg::REG_OUT_LOWER:   lim_lo = data[DW-1:0];
      default: ;
    endcase
  endtask

  // Stop offering requests, wait for every result, then let the pipeline empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offer one request after a random gap and record its expected result on acceptance.
  task automatic send_request(input logic clr, input logic signed [DW-1:0] sp,
                              input logic signed [DW-1:0] fb, input bit typed,
                              input pid_out_t typed_res);
    int unsigned gap;
    pid_out_t    res;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {fb, sp};
    s_tuser  <= clr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = predict_step(clr, sp, fb);
    drive_q.push_back(typed ? typed_res : res);
  endtask

  // Stimulus: directed table first, then random batches under changing settings.
  initial begin : stimulus
    bit                   dirty;
    int                   mode, hi, lo, nxt;
    int unsigned          pick, run_left;
    logic [GW-1:0]        gain [4];
    logic signed [DW-1:0] setpt, meas;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dirty = 1'b0;
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        if (dirty) settle();
        dirty = 1'b0;
        write_reg(PLAN[i].addr, PLAN[i].wdata);
      end else begin
        send_request(PLAN[i].clr, PLAN[i].sp, PLAN[i].fb, PLAN[i].typed,
                     {PLAN[i].exp_drive, PLAN[i].exp_clamped});
        dirty = 1'b1;
      end
    end

    for (int b = 0; b < BATCHES; b++) begin
      settle();
      // Settings: 0-2 nominal loop tuning, 3-4 anything, 5 extremes.
      mode = (b == 0) ? 0 : (b == 1) ? 5 : (b == 2) ? 3 : $urandom_range(0, 5);
      if (mode <= 2) begin
        gain[0] = GW'($urandom_range(24'h000400, 24'h040000));
        gain[1] = GW'($urandom_range(0, 24'h008000));
        gain[2] = GW'($urandom_range(0, 24'h010000));
        gain[3] = GW'($urandom_range(0, 24'h010000));
        hi = $urandom_range(0, 32767);
        lo = -int'($urandom_range(0, 32768));
      end else if (mode <= 4) begin
        foreach (gain[k]) gain[k] = GW'($urandom);
        hi = int'($urandom_range(0, 65535)) - 32768;
        lo = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        foreach (gain[k]) gain[k] = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        case ($urandom_range(0, 2))
          0: begin
            hi = 32767;
            lo = -32768;
          end
          1: begin
            hi = -32768;
            lo = 32767;
          end
          default: begin
            hi = int'($urandom_range(0, 65535)) - 32768;
            lo = hi;
          end
        endcase
      end
      write_reg(pidaw_pkg::REG_PROP_GAIN, gain[0]);
      write_reg(pidaw_pkg::REG_INTEG_GAIN, gain[1]);
      write_reg(pidaw_pkg::REG_DERIV_GAIN, gain[2]);
      write_reg(pidaw_pkg::REG_WINDUP_GAIN, gain[3]);
      write_reg(pidaw_pkg::REG_OUT_UPPER, GW'(hi));
      write_reg(pidaw_pkg::REG_OUT_LOWER, GW'(lo));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, GW'($urandom));

      // First batch runs flat out; the third backs up the block behind a held receiver.
      tx_idle = (b != 0) && ($urandom_range(0, 3) != 0);
      rx_idle = (b != 0) && ($urandom_range(0, 3) != 0);
      if (b == 2) begin
        tx_idle      = 1'b0;
        hold_results = 1'b1;
      end

      // Mostly tracking runs toward a held setpoint, with clears, noise and rail values.
      run_left = 0;
      for (int i = 0; i < BATCH_LEN; i++) begin
        if (i == BATCH_LEN / 2 && (b == 4 || $urandom_range(0, 7) == 0)) settle();
        if (run_left == 0) begin
          setpt    = DW'($urandom);
          meas     = DW'($urandom);
          run_left = $urandom_range(4, 30);
        end
        run_left--;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_request(1'b1, DW'($urandom), DW'($urandom), 1'b0, '0);
        end else if (pick < 10) begin
          send_request(1'b0, DW'($urandom), DW'($urandom), 1'b0, '0);
        end else if (pick < 16) begin
          send_request(1'b0, rail_sample(), rail_sample(), 1'b0, '0);
        end else begin
          nxt = int'(meas) + (int'(setpt) - int'(meas)) / 4 + int'($urandom_range(0, 64)) - 32;
          if (nxt > 32767) nxt = 32767;
          if (nxt < -32768) nxt = -32768;
          meas = DW'(nxt);
          send_request(1'b0, setpt, meas, 1'b0, '0);
        end
      end
    end

    settle();
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    pid_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("unexpected result at %0t: drive %0d clamped %0b",
                   $time, $signed(m_tdata), m_tuser[0]);
      end else begin
        want = drive_q.pop_front();
        if (m_tdata !== want.drive || m_tuser[0] !== want.clamped) begin
          mismatches++;
          if (mismatches <= SHOWN_MAX)
            $display("result mismatch at %0t: expected drive %0d clamped %0b, got %0d %0b",
                     $time, want.drive, want.clamped, $signed(m_tdata), m_tuser[0]);
        end
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: pid_antiwindup_controller.f
hw/rtl/pidaw_pkg.sv
hw/rtl/pidaw_mac.sv
hw/rtl/pidaw_ctrl.sv
hw/rtl/pid_antiwindup_controller.sv
tb/sv/tb.sv
